@@ sv/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, constants and round functions.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int QueueDepth = 4;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  // One classified item between the front and the back end
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } sha_item_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

endpackage

@@ sv/sha_queue.sv @@
// ----------------------------------------------------------------------------
// SHA item queue
// Small FIFO that decouples the input front end from the hashing back end.
// ----------------------------------------------------------------------------
module sha_queue import sha_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  sha_item_t wr_item,
  output logic      full,
  input  logic      rd_en,
  output sha_item_t rd_item,
  output logic      empty
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  sha_item_t         mem_r [Depth];
  logic [AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;

  assign full    = (cnt_r == (AW+1)'(Depth));
  assign empty   = (cnt_r == '0);
  assign rd_item = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      wp_nxt = (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
    end
    if (rd_en) begin
      rp_nxt = (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_item;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ sv/sha_core.sv @@
// ----------------------------------------------------------------------------
// SHA-256 back end
// Packs bytes into a block, pads, runs one round per cycle, emits digest.
// ----------------------------------------------------------------------------
module sha_core import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  sha_item_t   q_item,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_digest,
  output logic [2:0]  out_index,
  output logic        out_lastw
);

  localparam logic [2:0] S_TAKE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // step that follows the compression in progress
  localparam logic [1:0] N_TAKE = 2'd0;
  localparam logic [1:0] N_PAD  = 2'd1;
  localparam logic [1:0] N_LEN  = 2'd2;
  localparam logic [1:0] N_OUT  = 2'd3;

  logic [2:0]  st_r;
  logic [31:0] w_r [16];           // schedule window, also the block buffer
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [5:0]  fill_r, rnd_r;
  logic [60:0] len_r;
  logic [1:0]  follow_r;
  logic [2:0]  oidx_r;
  logic        ovld_r;

  logic [31:0] w_new, t1, t2, wt;
  logic [63:0] bits;
  logic [3:0]  fw;                 // word that holds the fill position
  logic [4:0]  fsh;                // bit offset of the fill byte in that word
  logic [31:0] pad_word;

  assign wt    = w_r[0];
  assign w_new = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];
  assign t1    = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
                 + ROUND_K[rnd_r] + wt;
  assign t2    = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  assign bits     = {len_r, 3'b000};
  assign fw       = fill_r[5:2];
  assign fsh      = {~fill_r[1:0], 3'b000};
  // keep the bytes before the fill position, put 0x80 there, clear the rest
  assign pad_word = (w_r[fw] & ~(32'hffffffff >> {fill_r[1:0], 3'b000}))
                    | (32'(PAD_BYTE) << fsh);

  assign q_pop      = (st_r == S_TAKE) && !q_empty;
  assign out_tvalid = ovld_r;
  assign out_digest = h_r[oidx_r];
  assign out_index  = oidx_r;
  assign out_lastw  = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_TAKE;
      fill_r   <= '0;
      len_r    <= '0;
      follow_r <= N_TAKE;
      ovld_r   <= 1'b0;
      oidx_r   <= '0;
      rnd_r    <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
    end else begin
      case (st_r)
        S_TAKE: begin
          if (!q_empty) begin
            if (q_item.byte_valid) begin
              w_r[fw][fsh +: 8] <= q_item.data_byte;
              len_r  <= len_r + 61'd1;
              fill_r <= fill_r + 6'd1;
            end
            if (q_item.byte_valid && fill_r == 6'd63) begin
              // block full: compress now, pad afterwards if this item ends the message
              st_r     <= S_RND;
              rnd_r    <= '0;
              follow_r <= q_item.last ? N_PAD : N_TAKE;
              for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
            end else if (q_item.last) begin
              st_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // 0x80 then zero fill to the end of the block
          for (int i = 0; i < 16; i++) begin
            if (4'(i) == fw) w_r[i] <= pad_word;
            else if (4'(i) > fw) w_r[i] <= '0;
          end
          if (fill_r >= LEN_POS) begin
            // length does not fit: compress this block, then a zero block
            st_r     <= S_RND;
            rnd_r    <= '0;
            fill_r   <= '0;
            follow_r <= N_LEN;
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          end else begin
            st_r <= S_LEN;
          end
        end
        S_LEN: begin
          w_r[14]  <= bits[63:32];
          w_r[15]  <= bits[31:0];
          st_r     <= S_RND;
          rnd_r    <= '0;
          fill_r   <= '0;
          follow_r <= N_OUT;
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        end
        S_RND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= w_new;
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          rnd_r  <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) st_r <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          case (follow_r)
            N_PAD: st_r <= S_PAD;
            N_LEN: begin
              st_r <= S_LEN;
              for (int i = 0; i < 14; i++) w_r[i] <= '0;
            end
            N_OUT: begin
              st_r   <= S_OUT;
              ovld_r <= 1'b1;
              oidx_r <= '0;
            end
            default: st_r <= S_TAKE;
          endcase
        end
        S_OUT: begin
          if (out_tready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              ovld_r <= 1'b0;
              st_r   <= S_TAKE;
              len_r  <= '0;
              for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
            end
          end
        end
        default: st_r <= S_TAKE;
      endcase
    end
  end

endmodule

@@ sv/sha256_byte_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a message given one byte per item and returns eight digest words.
// ----------------------------------------------------------------------------
// Input channel in_*: one byte per item, in_tuser marks the byte as part of
// the message, in_tlast ends the message (it may carry no byte).
// Output channel out_*: eight items per message, the digest words most
// significant first, out_tuser holds the word index, out_tlast the last.
// A front FIFO of four items takes input while the back end is busy.
// The core takes one item per cycle while it fills a block; each full block
// then runs through the one-round-per-cycle compression core (64 rounds,
// one add), during which new input waits in the FIFO. After last, padding
// and then the length are written; the first digest word follows their
// compression; if the length does not fit, a second block is compressed too.
// Reset loads the initial hash values and empties the FIFO. A stalled
// receiver holds the current digest word; input then backs up into the FIFO.
// After the eighth word the block is ready for the next message.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher import sha_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // byte_valid
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // digest_word
  output logic [2:0]  out_tuser,  // word_index
  output logic        out_tlast   // last_word
);

  sha_item_t in_item, q_item;
  logic      q_full, q_empty, q_pop;

  assign in_item   = '{data_byte: in_tdata, byte_valid: in_tuser, last: in_tlast};
  assign in_tready = !q_full;

  sha_queue #(.Depth(QDepth)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (in_tvalid && !q_full),
    .wr_item(in_item),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_item(q_item),
    .empty  (q_empty)
  );

  sha_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_digest(out_tdata),
    .out_index (out_tuser),
    .out_lastw (out_tlast)
  );

endmodule

@@ tb/sha256_digest_checker.sv @@
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both channels, hashes the accepted byte stream on its own and
// compares every digest word that leaves the block.
// ----------------------------------------------------------------------------
module sha256_digest_checker import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_words
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        final_word;
  } digest_word_t;

  logic [31:0]  hash_state [8];
  logic [7:0]   msg_block [64];
  int unsigned  block_fill;
  logic [60:0]  byte_count;
  digest_word_t digest_q [$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, e, a;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + w[t-7]
           + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
           + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      e = v[4];
      a = v[0];
      t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
         + ROUND_K[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) ^ 32'd0;
      t2 = t2 + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = e; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = a; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic start_message();
    for (int i = 0; i < 8; i++) hash_state[i] = INIT_H[i];
    block_fill = 0;
    byte_count = '0;
  endtask

  task automatic absorb_item(input logic [7:0] b, input logic has_byte, input logic fin);
    logic [63:0] bit_len;
    if (has_byte) begin
      msg_block[block_fill] = b;
      block_fill++;
      byte_count++;
      if (block_fill == 64) begin
        hash_block();
        block_fill = 0;
      end
    end
    if (fin) begin
      bit_len = {byte_count, 3'b000};
      msg_block[block_fill] = PAD_BYTE;
      block_fill++;
      if (block_fill > LEN_POS) begin
        while (block_fill < 64) begin
          msg_block[block_fill] = 8'h00;
          block_fill++;
        end
        hash_block();
        block_fill = 0;
      end
      while (block_fill < LEN_POS) begin
        msg_block[block_fill] = 8'h00;
        block_fill++;
      end
      for (int k = 0; k < 8; k++) msg_block[56+k] = bit_len[63-8*k -: 8];
      hash_block();
      for (int k = 0; k < 8; k++)
        digest_q.push_back(digest_word_t'{hash_state[k], 3'(k), k == 7});
      start_message();
    end
  endtask

  digest_word_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      start_message();
      digest_q.delete();
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) absorb_item(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected digest word %h index %0d", out_tdata, out_tuser);
        end else begin
          want = digest_q.pop_front();
          if (want != {out_tdata, out_tuser, out_tlast}) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                       want.word, want.index, want.final_word,
                       out_tdata, out_tuser, out_tlast);
          end
        end
      end
    end
    pending_words = digest_q.size();
  end

endmodule

@@ tb/sha256_byte_stream_hasher_test.sv @@
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher test
// Feeds directed and random messages with bursty input and a stalling
// receiver; the checker predicts and compares every digest word.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_test;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // data_byte
  logic        in_tuser;   // byte_valid
  logic        in_tlast;   // last
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // digest_word
  logic [2:0]  out_tuser;  // word_index
  logic        out_tlast;  // last_word
  int          fail_count;
  int          pending_words;
  int          cycle_count;
  logic        stall_mode;

  sha256_byte_stream_hasher dut (.*);

  sha256_digest_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run; slowest correct run is far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 300000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver stalls in phases: sometimes free running, sometimes choppy.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_mode <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
      out_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  int burst_left;

  task automatic send_item(input logic [7:0] b, input logic has_byte, input logic fin);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= has_byte;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_message(input int len, input logic tail_byte, input logic noise);
    for (int i = 0; i < len; i++) begin
      // hold last byte for the tail item when asked
      if (tail_byte && i == len - 1) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      else begin
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        if (noise && $urandom_range(0, 9) == 0)
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
    end
    if (!tail_byte || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message, then extreme bytes with last carrying a byte
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    drain();

    // padding edges: pad byte at offset 56 needs a second block,
    // and a last item that fills the block leaves a whole pad block
    send_message(56, 1'b1, 1'b0);
    send_message(64, 1'b1, 1'b0);
    drain();

    // a few short random messages
    for (int m = 0; m < 3; m++) begin
      send_message(int'($urandom_range(0, 4)), 1'($urandom_range(0, 1)), 1'b1);
    end

    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
